// ----- rtl/core/llc_fhc_pkg.sv -----
`default_nettype none

package llc_fhc_pkg;

    localparam logic [15:0] FCS_BYTES       = 16'd3;
    localparam logic [15:0] UI_SPAN_CAP     = 16'd7;
    localparam logic [5:0]  I_HDR_BYTES     = 6'd4;
    localparam logic [5:0]  UI_HDR_BYTES    = 6'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_PD    = 3'd2;
    localparam logic [2:0] ST_SAPI  = 3'd3;
    localparam logic [2:0] ST_UCMD  = 3'd4;

    localparam logic [1:0] FMT_I  = 2'd0;
    localparam logic [1:0] FMT_S  = 2'd1;
    localparam logic [1:0] FMT_UI = 2'd2;
    localparam logic [1:0] FMT_U  = 2'd3;

    localparam logic [3:0] CMD_NULL = 4'd0;
    localparam logic [3:0] CMD_RR   = 4'd1;
    localparam logic [3:0] CMD_DM   = 4'd5;
    localparam logic [3:0] CMD_DISC = 4'd6;
    localparam logic [3:0] CMD_UA   = 4'd7;
    localparam logic [3:0] CMD_SABM = 4'd8;
    localparam logic [3:0] CMD_FRMR = 4'd9;
    localparam logic [3:0] CMD_XID  = 4'd10;

    localparam logic [3:0] UC_NULL = 4'h0;
    localparam logic [3:0] UC_DM   = 4'h1;
    localparam logic [3:0] UC_DISC = 4'h4;
    localparam logic [3:0] UC_UA   = 4'h6;
    localparam logic [3:0] UC_SABM = 4'h7;
    localparam logic [3:0] UC_FRMR = 4'h8;
    localparam logic [3:0] UC_XID  = 4'hb;

    localparam logic [1:0] SUP_SACK = 2'd3;

    typedef struct packed {
        logic [7:0]  address_byte;
        logic [7:0]  control_byte0;
        logic [7:0]  control_byte1;
        logic [7:0]  control_byte2;
        logic [7:0]  control_byte3;
        logic [15:0] frame_length;
    } hdr_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  sapi;
        logic        is_command;
        logic        ack_request;
        logic        encrypted;
        logic [1:0]  frame_format;
        logic [3:0]  command_code;
        logic [8:0]  send_sequence;
        logic [8:0]  receive_sequence;
        logic        has_data;
        logic [5:0]  data_offset;
        logic [15:0] fcs_span;
    } res_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/llc_fhc_hdr_if.sv -----
`default_nettype none

interface llc_fhc_hdr_if;
    logic                  valid;
    logic                  ready;
    llc_fhc_pkg::hdr_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/llc_fhc_res_if.sv -----
`default_nettype none

interface llc_fhc_res_if;
    logic                  valid;
    logic                  ready;
    llc_fhc_pkg::res_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/llc_fhc_decode.sv -----
`default_nettype none

module llc_fhc_decode (
    input  llc_fhc_pkg::hdr_word_t hdr,
    output llc_fhc_pkg::res_word_t res
);

    logic [7:0]  addr;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic        sapi_rsvd;
    logic [15:0] span;

    assign addr = hdr.address_byte;
    assign c0   = hdr.control_byte0;
    assign c1   = hdr.control_byte1;
    assign c2   = hdr.control_byte2;
    assign c3   = hdr.control_byte3;
    assign span = hdr.frame_length - llc_fhc_pkg::FCS_BYTES;

    always_comb
    begin
        case (addr[3:0]) inside
            4'h0, 4'h4, 4'h6, 4'ha, 4'hc, 4'hd, 4'hf: sapi_rsvd = 1'b1;
            default:                                  sapi_rsvd = 1'b0;
        endcase
    end

    always_comb
    begin
        res = '0;
        if (hdr.frame_length <= llc_fhc_pkg::FCS_BYTES)
        begin
            res.status = llc_fhc_pkg::ST_SHORT;
        end
        else if (addr[7])
        begin
            res.status = llc_fhc_pkg::ST_PD;
        end
        else if (sapi_rsvd)
        begin
            res.status = llc_fhc_pkg::ST_SAPI;
        end
        else
        begin
            res.status     = llc_fhc_pkg::ST_OK;
            res.sapi       = addr[3:0];
            res.is_command = ~addr[6];
            res.fcs_span   = span;
            if (!c0[7])
            begin
                res.frame_format     = llc_fhc_pkg::FMT_I;
                res.has_data         = 1'b1;
                res.ack_request      = c0[6];
                res.send_sequence    = {c0[4:0], c1[7:4]};
                res.receive_sequence = {c1[2:0], c2[7:2]};
                res.command_code     = llc_fhc_pkg::CMD_RR + {2'b00, c2[1:0]};
                if (c2[1:0] == llc_fhc_pkg::SUP_SACK)
                begin
                    res.data_offset = llc_fhc_pkg::I_HDR_BYTES + 6'd1 + {1'b0, c3[4:0]};
                end
                else
                begin
                    res.data_offset = llc_fhc_pkg::I_HDR_BYTES;
                end
            end
            else if (!c0[6])
            begin
                res.frame_format     = llc_fhc_pkg::FMT_S;
                res.ack_request      = c0[5];
                res.receive_sequence = {c0[2:0], c1[7:2]};
                res.command_code     = llc_fhc_pkg::CMD_RR + {2'b00, c1[1:0]};
            end
            else if (!c0[5])
            begin
                res.frame_format  = llc_fhc_pkg::FMT_UI;
                res.has_data      = 1'b1;
                res.data_offset   = llc_fhc_pkg::UI_HDR_BYTES;
                res.send_sequence = {c0[2:0], c1[7:2]};
                res.encrypted     = c1[1];
                if (!c1[0] && span > llc_fhc_pkg::UI_SPAN_CAP)
                begin
                    res.fcs_span = llc_fhc_pkg::UI_SPAN_CAP;
                end
            end
            else
            begin
                res.frame_format = llc_fhc_pkg::FMT_U;
                unique case (c0[3:0])
                    llc_fhc_pkg::UC_NULL: res.command_code = llc_fhc_pkg::CMD_NULL;
                    llc_fhc_pkg::UC_DM:   res.command_code = llc_fhc_pkg::CMD_DM;
                    llc_fhc_pkg::UC_DISC: res.command_code = llc_fhc_pkg::CMD_DISC;
                    llc_fhc_pkg::UC_UA:   res.command_code = llc_fhc_pkg::CMD_UA;
                    llc_fhc_pkg::UC_SABM: res.command_code = llc_fhc_pkg::CMD_SABM;
                    llc_fhc_pkg::UC_FRMR: res.command_code = llc_fhc_pkg::CMD_FRMR;
                    llc_fhc_pkg::UC_XID:  res.command_code = llc_fhc_pkg::CMD_XID;
                    default:              res.status       = llc_fhc_pkg::ST_UCMD;
                endcase
            end
            if (res.status != llc_fhc_pkg::ST_OK)
            begin
                res        = '0;
                res.status = llc_fhc_pkg::ST_UCMD;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/llc_frame_header_classifier_core.sv -----
// LLC frame header classifier.
// hdr: one word per received frame: address byte, four control bytes and
//      total frame length (FCS included). Taken when valid and ready are high.
// res: one word per header: status, SAPI, C/R, format, command code,
//      N(S)/N(R), information field offset and FCS span.
// Pipeline: header register, decode logic, result register.
// A taken word is held in the header register, decoded there, and loaded into
// the result register as soon as that register is empty or being read.
// Throughput: one word per cycle while res.ready is high; then both stages advance together.
// Reset (rst_n low, async) empties both stages; res.valid drops at once.
// When res.ready is low the result is held; the header stage fills up and
// then hdr.ready drops, so nothing is lost. hdr.ready follows res.ready
// combinationally through the two stage-free terms.
`default_nettype none

module llc_frame_header_classifier_core (
    input  wire            clk,
    input  wire            rst_n,
    llc_fhc_hdr_if.sink    hdr,
    llc_fhc_res_if.source  res
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    llc_fhc_pkg::hdr_word_t s1_data_reg;
    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    llc_fhc_pkg::res_word_t s2_data_reg;
    llc_fhc_pkg::res_word_t dec_res;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   s1_load;
    logic                   s2_load;

    assign s2_ready = ~s2_valid_reg | res.ready;
    assign s1_ready = ~s1_valid_reg | s2_ready;
    assign s1_load  = hdr.valid & s1_ready;
    assign s2_load  = s1_valid_reg & s2_ready;

    assign s1_valid_next = s1_load | (s1_valid_reg & ~s2_ready);
    assign s2_valid_next = s2_load | (s2_valid_reg & ~res.ready);

    llc_fhc_decode u_decode (
        .hdr (s1_data_reg),
        .res (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= hdr.data;
        end
        if (s2_load)
        begin
            s2_data_reg <= dec_res;
        end
    end

    assign hdr.ready = s1_ready;
    assign res.valid = s2_valid_reg;
    assign res.data  = s2_data_reg;

    a_s2_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_ready |=> res.valid)
        else $error("decoded word not registered");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.status != llc_fhc_pkg::ST_OK |->
            res.data.sapi == 4'd0 && res.data.fcs_span == 16'd0 &&
            res.data.command_code == 4'd0 && !res.data.has_data)
        else $error("error word carries fields");

    a_data_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.has_data |->
            res.data.frame_format == llc_fhc_pkg::FMT_I ||
            res.data.frame_format == llc_fhc_pkg::FMT_UI)
        else $error("data flag on S or U frame");

endmodule

`default_nettype wire

// ----- tb/llc_frame_header_classifier_core_test.sv -----
`default_nettype none

module llc_frame_header_classifier_core_test;

    import llc_fhc_pkg::*;

    localparam int unsigned RANDOM_HEADERS = 1525;
    localparam int unsigned HOLD_AT        = 300;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned QUIET_LIMIT    = 1000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    class hdr_result_board;
        res_word_t   pending_results [$];
        int unsigned mismatches;
        int unsigned headers_seen;
        int unsigned results_seen;
        int unsigned format_hits [4];
        int unsigned reject_hits [5];

        function bit sapi_is_reserved(logic [3:0] s);
            case (s)
                4'h0, 4'h4, 4'h6, 4'ha, 4'hc, 4'hd, 4'hf: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function res_word_t classify_frame(hdr_word_t h);
            res_word_t r;
            logic [7:0] c0;
            logic [7:0] c1;
            logic [7:0] c2;
            bit         bad_ucmd;
            r = '0;
            c0 = h.control_byte0;
            c1 = h.control_byte1;
            c2 = h.control_byte2;
            bad_ucmd = 1'b0;
            if (h.frame_length <= FCS_BYTES)
                r.status = ST_SHORT;
            else if (h.address_byte[7])
                r.status = ST_PD;
            else if (sapi_is_reserved(h.address_byte[3:0]))
                r.status = ST_SAPI;
            else
            begin
                r.status     = ST_OK;
                r.sapi       = h.address_byte[3:0];
                r.is_command = ~h.address_byte[6];
                r.fcs_span   = h.frame_length - FCS_BYTES;
                if (!c0[7])
                begin
                    r.frame_format     = FMT_I;
                    r.has_data         = 1'b1;
                    r.ack_request      = c0[6];
                    r.send_sequence    = {c0[4:0], c1[7:4]};
                    r.receive_sequence = {c1[2:0], c2[7:2]};
                    r.command_code     = CMD_RR + {2'b00, c2[1:0]};
                    if (c2[1:0] == SUP_SACK)
                        r.data_offset = I_HDR_BYTES + 6'd1 + {1'b0, h.control_byte3[4:0]};
                    else
                        r.data_offset = I_HDR_BYTES;
                end
                else if (!c0[6])
                begin
                    r.frame_format     = FMT_S;
                    r.ack_request      = c0[5];
                    r.receive_sequence = {c0[2:0], c1[7:2]};
                    r.command_code     = CMD_RR + {2'b00, c1[1:0]};
                end
                else if (!c0[5])
                begin
                    r.frame_format  = FMT_UI;
                    r.has_data      = 1'b1;
                    r.data_offset   = UI_HDR_BYTES;
                    r.send_sequence = {c0[2:0], c1[7:2]};
                    r.encrypted     = c1[1];
                    // unprotected mode: FCS only covers header plus first info bytes
                    if (!c1[0] && r.fcs_span > UI_SPAN_CAP)
                        r.fcs_span = UI_SPAN_CAP;
                end
                else
                begin
                    r.frame_format = FMT_U;
                    case (c0[3:0])
                        UC_NULL: r.command_code = CMD_NULL;
                        UC_DM:   r.command_code = CMD_DM;
                        UC_DISC: r.command_code = CMD_DISC;
                        UC_UA:   r.command_code = CMD_UA;
                        UC_SABM: r.command_code = CMD_SABM;
                        UC_FRMR: r.command_code = CMD_FRMR;
                        UC_XID:  r.command_code = CMD_XID;
                        default: bad_ucmd = 1'b1;
                    endcase
                end
                if (bad_ucmd)
                begin
                    r = '0;
                    r.status = ST_UCMD;
                end
            end
            return r;
        endfunction

        function void note_header(hdr_word_t h);
            pending_results.push_back(classify_frame(h));
            headers_seen++;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(res_word_t got);
            res_word_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (want.status == ST_OK)
                format_hits[want.frame_format]++;
            else
                reject_hits[want.status]++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("sapi", 16'(want.sapi), 16'(got.sapi));
            compare_field("is_command", 16'(want.is_command), 16'(got.is_command));
            compare_field("ack_request", 16'(want.ack_request), 16'(got.ack_request));
            compare_field("encrypted", 16'(want.encrypted), 16'(got.encrypted));
            compare_field("frame_format", 16'(want.frame_format), 16'(got.frame_format));
            compare_field("command_code", 16'(want.command_code), 16'(got.command_code));
            compare_field("send_sequence", 16'(want.send_sequence),
                          16'(got.send_sequence));
            compare_field("receive_sequence", 16'(want.receive_sequence),
                          16'(got.receive_sequence));
            compare_field("has_data", 16'(want.has_data), 16'(got.has_data));
            compare_field("data_offset", 16'(want.data_offset), 16'(got.data_offset));
            compare_field("fcs_span", want.fcs_span, got.fcs_span);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    llc_fhc_hdr_if hdr_ch ();
    llc_fhc_res_if res_ch ();

    hdr_result_board board;

    llc_frame_header_classifier_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic hdr_word_t pack_header(logic [7:0] a, logic [7:0] c0, logic [7:0] c1,
                                              logic [7:0] c2, logic [7:0] c3,
                                              logic [15:0] len);
        hdr_word_t h;
        h.address_byte  = a;
        h.control_byte0 = c0;
        h.control_byte1 = c1;
        h.control_byte2 = c2;
        h.control_byte3 = c3;
        h.frame_length  = len;
        return h;
    endfunction

    function automatic logic [3:0] pick_usable_sapi();
        case ($urandom_range(0, 8))
            0: return 4'd1;
            1: return 4'd2;
            2: return 4'd3;
            3: return 4'd5;
            4: return 4'd7;
            5: return 4'd8;
            6: return 4'd9;
            7: return 4'd11;
            default: return 4'd14;
        endcase
    endfunction

    function automatic logic [3:0] pick_ucmd();
        case ($urandom_range(0, 6))
            0: return UC_NULL;
            1: return UC_DM;
            2: return UC_DISC;
            3: return UC_UA;
            4: return UC_SABM;
            5: return UC_FRMR;
            default: return UC_XID;
        endcase
    endfunction

    function automatic hdr_word_t make_random_header();
        hdr_word_t h;
        h.address_byte  = 8'($urandom_range(0, 255));
        h.control_byte0 = 8'($urandom_range(0, 255));
        h.control_byte1 = 8'($urandom_range(0, 255));
        h.control_byte2 = 8'($urandom_range(0, 255));
        h.control_byte3 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8)
        begin
            h.address_byte[7]   = 1'b0;
            h.address_byte[3:0] = pick_usable_sapi();
        end
        case ($urandom_range(0, 3))
            0: h.control_byte0[7] = 1'b0;
            1: h.control_byte0[7:6] = 2'b10;
            2: h.control_byte0[7:5] = 3'b110;
            default:
            begin
                h.control_byte0[7:5] = 3'b111;
                if ($urandom_range(0, 3) != 0)
                    h.control_byte0[3:0] = pick_ucmd();
            end
        endcase
        case ($urandom_range(0, 9))
            0: h.frame_length = 16'($urandom_range(0, 10));
            1: h.frame_length = 16'($urandom_range(0, 65535));
            default: h.frame_length = 16'($urandom_range(4, 300));
        endcase
        return h;
    endfunction

    task automatic offer_header(input hdr_word_t w, input int unsigned gap);
        if (gap != 0)
        begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr_ch.valid <= 1'b1;
        hdr_ch.data  <= w;
        @(posedge clk);
        while (!hdr_ch.ready)
            @(posedge clk);
        board.note_header(w);
        @(negedge clk);
    endtask

    task automatic send_all_headers();
        hdr_word_t   directed [$];
        int unsigned gap;
        int unsigned k;
        directed.push_back(pack_header(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
        directed.push_back(pack_header(8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 16'd3));
        directed.push_back(pack_header(8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 16'd4));
        directed.push_back(pack_header(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 16'd100));
        directed.push_back(pack_header(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd100));
        directed.push_back(pack_header(8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 16'd100));
        directed.push_back(pack_header(8'h0e, 8'h7f, 8'hff, 8'hfc, 8'h00, 16'd65535));
        directed.push_back(pack_header(8'h07, 8'h00, 8'h00, 8'hff, 8'hff, 16'd40));
        directed.push_back(pack_header(8'h09, 8'ha7, 8'hfc, 8'h00, 8'h00, 16'd10));
        directed.push_back(pack_header(8'h0b, 8'h80, 8'h01, 8'h00, 8'h00, 16'd10));
        directed.push_back(pack_header(8'h01, 8'h98, 8'h02, 8'h00, 8'h00, 16'd10));
        directed.push_back(pack_header(8'h02, 8'h80, 8'h03, 8'h00, 8'h00, 16'd9));
        directed.push_back(pack_header(8'h03, 8'hc7, 8'hff, 8'h00, 8'h00, 16'd1000));
        directed.push_back(pack_header(8'h03, 8'hc0, 8'h02, 8'h00, 8'h00, 16'd1000));
        directed.push_back(pack_header(8'h05, 8'hc1, 8'h00, 8'h00, 8'h00, 16'd10));
        directed.push_back(pack_header(8'h08, 8'hc2, 8'h04, 8'h00, 8'h00, 16'd5));
        directed.push_back(pack_header(8'h01, {4'he, UC_NULL}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h41, {4'he, UC_DM}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h01, {4'hf, UC_DISC}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h01, {4'he, UC_UA}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h01, {4'hf, UC_SABM}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h01, {4'he, UC_FRMR}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h01, {4'he, UC_XID}, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h01, 8'he2, 8'h00, 8'h00, 8'h00, 16'd6));
        directed.push_back(pack_header(8'h0e, 8'hff, 8'hff, 8'hff, 8'hff, 16'd6));
        @(negedge clk);
        foreach (directed[i])
            offer_header(directed[i], $urandom_range(0, 5));
        for (k = 0; k < RANDOM_HEADERS; k++)
        begin
            gap = ((k / 150) % 4 == 3) ? 0 : $urandom_range(0, 5);
            offer_header(make_random_header(), gap);
        end
        hdr_ch.valid <= 1'b0;
    endtask

    task automatic collect_results();
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        @(negedge clk);
        forever
        begin
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((taken / 200) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            board.check_result(res_ch.data);
            taken++;
            @(negedge clk);
        end
    endtask

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet == QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("** llc_frame_header_classifier_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        hdr_ch.valid = 1'b0;
        hdr_ch.data  = '0;
        res_ch.ready = 1'b0;
        board = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        fork
            collect_results();
        join_none
        send_all_headers();
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d frame headers and %0d results;",
                 board.headers_seen, board.results_seen);
        $display("accepted I %0d, S %0d, UI %0d, U %0d.",
                 board.format_hits[FMT_I], board.format_hits[FMT_S],
                 board.format_hits[FMT_UI], board.format_hits[FMT_U]);
        $display("Rejected: too short %0d, PD set %0d, reserved SAPI %0d, unknown U command %0d.",
                 board.reject_hits[ST_SHORT], board.reject_hits[ST_PD],
                 board.reject_hits[ST_SAPI], board.reject_hits[ST_UCMD]);
        if (board.mismatches == 0)
            $display("** llc_frame_header_classifier_core: PASSED **");
        else
            $display("** llc_frame_header_classifier_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
